FILE: rtl/core/seb_pkg.sv
package seb_pkg;

  localparam int WORD_COUNT   = 64;
  localparam int ADDRESS_BITS = 6;
  localparam int WORD_BITS    = 16;

  localparam int ABL_W     = $clog2(ADDRESS_BITS + 1);
  localparam int DBL_W     = $clog2(WORD_BITS + 1);
  localparam int BIT_IDX_W = $clog2(WORD_BITS);
  localparam int MEM_IDX_W = $clog2(WORD_COUNT);
  localparam bit FULL_MAP  = (WORD_COUNT == (1 << ADDRESS_BITS));

  localparam logic [WORD_BITS-1:0] WORD_ONES = '1;
  localparam logic [ABL_W-1:0]     ABL_INIT  = ABL_W'(ADDRESS_BITS);
  localparam logic [DBL_W-1:0]     DBL_INIT  = DBL_W'(WORD_BITS);

  localparam logic [23:0] PORT_DO = 24'hF14001;
  localparam logic [23:0] PORT_DI = 24'hF14801;
  localparam logic [23:0] PORT_CS = 24'hF15001;

  localparam logic OPER_READ  = 1'b0;
  localparam logic OPER_WRITE = 1'b1;

  localparam logic [1:0] OPC_EXT   = 2'b00;
  localparam logic [1:0] OPC_WRITE = 2'b01;
  localparam logic [1:0] OPC_READ  = 2'b10;
  localparam logic [1:0] OPC_ERASE = 2'b11;

  localparam logic [1:0] SUB_EWDS = 2'b00;
  localparam logic [1:0] SUB_WRAL = 2'b01;
  localparam logic [1:0] SUB_ERAL = 2'b10;
  localparam logic [1:0] SUB_EWEN = 2'b11;

  function automatic logic addr_in_store(logic [ADDRESS_BITS-1:0] a);
    return FULL_MAP || (int'(a) < WORD_COUNT);
  endfunction

endpackage

FILE: rtl/core/serial_eeprom_bus_interface.sv
// A transaction is accepted in the idle state and executed in the execute state, which
// waits while an earlier result is stalled; no new transaction is taken until it is done.
// Write-all and erase-all take effect through per-word valid bits.
// Reset (rst, synchronous) restarts the command machine, clears write enable and
// makes every word read as all ones.
module serial_eeprom_bus_interface
  import seb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        operation,
  input  logic [23:0] address,
  input  logic [7:0]  write_data,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  read_data
);

  typedef enum logic {S_IDLE, S_EXEC} seq_t;
  typedef enum logic [1:0] {P_NONE, P_DO, P_DI, P_CS} port_t;
  typedef enum logic [2:0] {
    M_START, M_OP_HI, M_OP_LO, M_ADDR, M_DATA, M_BUSY, M_READING
  } mstate_t;

  seq_t                     seq, seq_next;
  mstate_t                  mstate, mstate_next;
  port_t                    req_port;
  logic                     req_bit;
  logic [1:0]               opcode, opcode_next;
  logic [ADDRESS_BITS-1:0]  address_shift, address_shift_next;
  logic [ABL_W-1:0]         address_bits_left, address_bits_left_next;
  logic [WORD_BITS-1:0]     data_shift, data_shift_next;
  logic [DBL_W-1:0]         data_bits_left, data_bits_left_next;
  logic                     write_enable, write_enable_next;
  logic [WORD_COUNT-1:0]    word_valid, word_valid_next;
  logic [WORD_BITS-1:0]     fill_word, fill_word_next;
  logic                     rsp_valid_next;
  logic [7:0]               read_data_next;
  logic                     rd_hit, rd_in;
  logic [WORD_BITS-1:0]     mem_rdata;
  logic [WORD_BITS-1:0]     mem [WORD_COUNT];

  logic                     accept;
  port_t                    port_dec;
  logic                     mem_we;
  logic [ADDRESS_BITS-1:0]  mem_waddr;
  logic [WORD_BITS-1:0]     mem_wdata;
  logic [WORD_BITS-1:0]     rword;
  logic [ADDRESS_BITS-1:0]  ash_sh;
  logic [WORD_BITS-1:0]     dsh_sh;
  logic [ABL_W-1:0]         abl_dec;
  logic [DBL_W-1:0]         dbl_dec;

  assign req_stall = (seq != S_IDLE);
  assign accept    = req_valid && (seq == S_IDLE);

  always_comb begin
    priority if (address == PORT_CS) begin
      port_dec = P_CS;
    end else if (address == PORT_DO && operation == OPER_READ) begin
      port_dec = P_DO;
    end else if (address == PORT_DI && operation == OPER_WRITE) begin
      port_dec = P_DI;
    end else begin
      port_dec = P_NONE;
    end
  end

  assign rword   = rd_hit ? mem_rdata : (rd_in ? fill_word : WORD_ONES);
  assign ash_sh  = {address_shift[ADDRESS_BITS-2:0], req_bit};
  assign dsh_sh  = {data_shift[WORD_BITS-2:0], req_bit};
  assign abl_dec = address_bits_left - ABL_W'(1);
  assign dbl_dec = data_bits_left - DBL_W'(1);

  always_comb begin
    seq_next               = seq;
    mstate_next            = mstate;
    opcode_next            = opcode;
    address_shift_next     = address_shift;
    address_bits_left_next = address_bits_left;
    data_shift_next        = data_shift;
    data_bits_left_next    = data_bits_left;
    write_enable_next      = write_enable;
    word_valid_next        = word_valid;
    fill_word_next         = fill_word;
    rsp_valid_next         = rsp_valid && rsp_stall;
    read_data_next         = read_data;
    mem_we                 = 1'b0;
    mem_waddr              = address_shift;
    mem_wdata              = WORD_ONES;

    unique case (seq)
      S_IDLE: begin
        if (req_valid) begin
          seq_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!rsp_valid || !rsp_stall) begin
          seq_next       = S_IDLE;
          rsp_valid_next = 1'b1;
          read_data_next = '0;
          unique case (req_port)
            P_CS: begin
              mstate_next            = M_START;
              opcode_next            = OPC_EXT;
              address_shift_next     = '0;
              address_bits_left_next = ABL_INIT;
              data_shift_next        = '0;
              data_bits_left_next    = DBL_INIT;
              write_enable_next      = 1'b1;
            end
            P_DO: begin
              read_data_next[0] = 1'b1;
              if (mstate == M_BUSY) begin
                mstate_next       = M_START;
                read_data_next[0] = 1'b0;
              end else if (mstate == M_READING) begin
                data_bits_left_next = dbl_dec;
                read_data_next[0]   = rword[dbl_dec[BIT_IDX_W-1:0]];
                if (dbl_dec == '0) begin
                  mstate_next = M_START;
                end
              end
            end
            P_DI: begin
              unique case (mstate)
                M_START: begin
                  mstate_next = M_OP_HI;
                end
                M_OP_HI: begin
                  opcode_next = {req_bit, 1'b0};
                  mstate_next = M_OP_LO;
                end
                M_OP_LO: begin
                  opcode_next            = {opcode[1], req_bit};
                  mstate_next            = M_ADDR;
                  address_shift_next     = '0;
                  address_bits_left_next = ABL_INIT;
                  if ({opcode[1], req_bit} == OPC_READ) begin
                    data_shift_next     = '0;
                    data_bits_left_next = DBL_INIT;
                  end
                end
                M_ADDR: begin
                  address_shift_next     = ash_sh;
                  address_bits_left_next = abl_dec;
                  if (abl_dec == '0) begin
                    unique case (opcode)
                      OPC_EXT: begin
                        unique case (ash_sh[ADDRESS_BITS-1 -: 2])
                          SUB_EWDS: begin
                            write_enable_next = 1'b0;
                            mstate_next       = M_START;
                          end
                          SUB_WRAL: begin
                            mstate_next         = M_DATA;
                            data_shift_next     = '0;
                            data_bits_left_next = DBL_INIT;
                          end
                          SUB_ERAL: begin
                            if (write_enable) begin
                              word_valid_next = '0;
                              fill_word_next  = WORD_ONES;
                            end
                            mstate_next = M_BUSY;
                          end
                          SUB_EWEN: begin
                            write_enable_next = 1'b1;
                            mstate_next       = M_START;
                          end
                          default: ;
                        endcase
                      end
                      OPC_WRITE: begin
                        mstate_next         = M_DATA;
                        data_shift_next     = '0;
                        data_bits_left_next = DBL_INIT;
                      end
                      OPC_READ: begin
                        mstate_next = M_READING;
                      end
                      OPC_ERASE: begin
                        if (write_enable && addr_in_store(ash_sh)) begin
                          mem_we    = 1'b1;
                          mem_waddr = ash_sh;
                          word_valid_next[ash_sh[MEM_IDX_W-1:0]] = 1'b1;
                        end
                        mstate_next = M_BUSY;
                      end
                      default: ;
                    endcase
                  end
                end
                M_DATA: begin
                  data_shift_next     = dsh_sh;
                  data_bits_left_next = dbl_dec;
                  if (dbl_dec == '0) begin
                    if (opcode == OPC_EXT) begin
                      if (write_enable) begin
                        word_valid_next = '0;
                        fill_word_next  = dsh_sh;
                      end
                    end else if (write_enable && addr_in_store(address_shift)) begin
                      mem_we    = 1'b1;
                      mem_wdata = dsh_sh;
                      word_valid_next[address_shift[MEM_IDX_W-1:0]] = 1'b1;
                    end
                    mstate_next = M_BUSY;
                  end
                end
                M_BUSY, M_READING: begin
                  mstate_next = M_OP_HI;
                end
                default: begin
                  mstate_next = M_OP_HI;
                end
              endcase
            end
            P_NONE: ;
            default: ;
          endcase
        end
      end
      default: seq_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq               <= S_IDLE;
      mstate            <= M_START;
      opcode            <= OPC_EXT;
      address_shift     <= '0;
      address_bits_left <= ABL_INIT;
      data_shift        <= '0;
      data_bits_left    <= DBL_INIT;
      write_enable      <= 1'b0;
      word_valid        <= '0;
      fill_word         <= WORD_ONES;
      rsp_valid         <= 1'b0;
      read_data         <= '0;
    end else begin
      seq               <= seq_next;
      mstate            <= mstate_next;
      opcode            <= opcode_next;
      address_shift     <= address_shift_next;
      address_bits_left <= address_bits_left_next;
      data_shift        <= data_shift_next;
      data_bits_left    <= data_bits_left_next;
      write_enable      <= write_enable_next;
      word_valid        <= word_valid_next;
      fill_word         <= fill_word_next;
      rsp_valid         <= rsp_valid_next;
      read_data         <= read_data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_port <= port_dec;
      req_bit  <= write_data[0];
      rd_hit   <= word_valid[address_shift[MEM_IDX_W-1:0]] && addr_in_store(address_shift);
      rd_in    <= addr_in_store(address_shift);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr[MEM_IDX_W-1:0]] <= mem_wdata;
    end
    if (accept) begin
      mem_rdata <= mem[address_shift[MEM_IDX_W-1:0]];
    end
  end

endmodule

FILE: rtl/core/seb_checker.sv
module seb_checker
  import seb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic        operation,
  input logic [23:0] address,
  input logic [7:0]  write_data,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [7:0]  read_data
);

  // A stalled result holds its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data))
    else $error("stalled result changed or dropped");

  // Only the serial data-out bit can be nonzero.
  a_rsp_bits: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> read_data[7:1] == 7'd0)
    else $error("upper result bits not zero");

  // One transaction at a time: the request side stalls right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second transaction accepted while one is in progress");

  // Every accepted transaction is to have its result presented; a stalled earlier result can hold it back.
  a_result_due: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |-> ##2 rsp_valid)
    else $error("result missing two cycles after accept");

endmodule

bind serial_eeprom_bus_interface seb_checker u_seb_checker (.*);

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import seb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'd1, S_OPC_HI, S_OPC_LO, S_EXT, S_WRITE, S_READ, S_ERASE, S_SUB,
    S_ADDR, S_EWDS, S_WRAL, S_ERAL, S_EWEN, S_WRAL_GO, S_DATA, S_BUSY,
    S_WRITE_ADDR, S_WRITE_GO, S_READING, S_ERASE_GO
  } cmd_state_t;

  // Tracks the command machine and the word store, and keeps the read bytes
  // that the accepted transactions must return, oldest first.
  class eeprom_bus_tracker;
    cmd_state_t              mstate;
    cmd_state_t              ret_state;
    logic [1:0]              opc;
    logic [ADDRESS_BITS-1:0] addr_sr;
    logic [3:0]              addr_left;
    logic [WORD_BITS-1:0]    data_sr;
    logic [4:0]              data_left;
    bit                      wen;
    bit                      chain;
    logic [WORD_BITS-1:0]    words [WORD_COUNT];
    logic [7:0]              expected_read_bytes [$];
    int                      fail_count;

    function void fill_words(logic [WORD_BITS-1:0] v);
      foreach (words[i]) words[i] = v;
    endfunction

    function void put_word(logic [ADDRESS_BITS-1:0] a, logic [WORD_BITS-1:0] v);
      if (int'(a) < WORD_COUNT) words[a] = v;
    endfunction

    function void restart();
      mstate    = S_IDLE;
      opc       = '0;
      ret_state = S_IDLE;
      addr_sr   = '0;
      addr_left = 4'(ADDRESS_BITS);
      data_sr   = '0;
      data_left = 5'(WORD_BITS);
      wen       = 1'b1;
    endfunction

    function void clear();
      restart();
      wen        = 1'b0;
      chain      = 1'b0;
      fail_count = 0;
      fill_words('1);
      expected_read_bytes.delete();
    endfunction

    function void open_address(cmd_state_t next, bit set_chain);
      ret_state = next;
      mstate    = S_ADDR;
      addr_left = 4'(ADDRESS_BITS);
      addr_sr   = '0;
      if (set_chain) chain = 1'b1;
    endfunction

    function void open_data(cmd_state_t next);
      ret_state = next;
      mstate    = S_DATA;
      data_left = 5'(WORD_BITS);
      data_sr   = '0;
      chain     = 1'b1;
    endfunction

    // Returns 1 when the same data-in bit must be taken again by the new state.
    function bit clock_in(bit d);
      case (mstate)
        S_IDLE: mstate = S_OPC_HI;
        S_OPC_HI: begin
          opc    = {d, 1'b0};
          mstate = S_OPC_LO;
        end
        S_OPC_LO: begin
          opc[0] = d;
          chain  = 1'b0;
          case (opc)
            OPC_EXT:   mstate = S_EXT;
            OPC_WRITE: mstate = S_WRITE;
            OPC_READ:  mstate = S_READ;
            default:   mstate = S_ERASE;
          endcase
          return 1'b1;
        end
        S_EXT: open_address(S_SUB, 1'b1);
        S_SUB: begin
          case (addr_sr[ADDRESS_BITS-1 -: 2])
            SUB_EWDS: mstate = S_EWDS;
            SUB_WRAL: mstate = S_WRAL;
            SUB_ERAL: mstate = S_ERAL;
            default:  mstate = S_EWEN;
          endcase
          return 1'b1;
        end
        S_EWDS: begin
          wen    = 1'b0;
          mstate = S_IDLE;
        end
        S_WRAL: open_data(S_WRAL_GO);
        S_WRAL_GO: begin
          if (wen) fill_words(data_sr);
          mstate = S_BUSY;
        end
        S_ERAL: begin
          if (wen) fill_words('1);
          mstate = S_BUSY;
        end
        S_EWEN: begin
          wen    = 1'b1;
          mstate = S_IDLE;
        end
        S_WRITE: open_address(S_WRITE_ADDR, 1'b1);
        S_WRITE_ADDR: open_data(S_WRITE_GO);
        S_WRITE_GO: begin
          if (wen) put_word(addr_sr, data_sr);
          mstate = S_BUSY;
        end
        S_READ: begin
          open_address(S_READING, 1'b0);
          data_left = 5'(WORD_BITS);
          data_sr   = '0;
        end
        S_ERASE: open_address(S_ERASE_GO, 1'b1);
        S_ERASE_GO: begin
          if (wen) put_word(addr_sr, '1);
          mstate = S_BUSY;
        end
        S_DATA: begin
          data_sr   = {data_sr[WORD_BITS-2:0], d};
          data_left = data_left - 5'd1;
          if (data_left == 5'd0) begin
            mstate = ret_state;
            return chain;
          end
        end
        S_ADDR: begin
          addr_sr   = {addr_sr[ADDRESS_BITS-2:0], d};
          addr_left = addr_left - 4'd1;
          if (addr_left == 4'd0) begin
            mstate = ret_state;
            return chain;
          end
        end
        default: mstate = S_OPC_HI;
      endcase
      return 1'b0;
    endfunction

    function bit shift_out();
      bit                   b;
      logic [WORD_BITS-1:0] w;
      b = 1'b1;
      if (mstate == S_BUSY) begin
        mstate = S_IDLE;
        b      = 1'b0;
      end else if (mstate == S_READING) begin
        data_left = data_left - 5'd1;
        w = (int'(addr_sr) < WORD_COUNT) ? words[addr_sr] : '1;
        b = (data_left < 5'd16) ? w[data_left[3:0]] : 1'b0;
        if (data_left == 5'd0) mstate = S_IDLE;
      end
      return b;
    endfunction

    function void note_access(logic op, logic [23:0] a, logic [7:0] wd);
      logic [7:0] rd;
      rd = 8'h00;
      if (op == OPER_READ) begin
        if (a == PORT_DO) rd = {7'b0, shift_out()};
        else if (a == PORT_CS) restart();
      end else begin
        if (a == PORT_DI) begin
          while (clock_in(wd[0])) begin
          end
        end else if (a == PORT_CS) begin
          restart();
        end
      end
      expected_read_bytes.push_back(rd);
    endfunction

    function void check_read_data(logic [7:0] got);
      logic [7:0] want;
      if (expected_read_bytes.size() == 0) begin
        $error("read_data %0h returned with no transaction outstanding", got);
        fail_count++;
        return;
      end
      want = expected_read_bytes.pop_front();
      if (got !== want) begin
        $error("read_data mismatch: expected %0h, actual %0h", want, got);
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_read_bytes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic        operation;
  logic [23:0] address;
  logic [7:0]  write_data;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [7:0]  read_data;

  eeprom_bus_tracker tracker;
  int items_sent;
  int req_idle_pct;
  int rsp_idle_pct;
  int hold_requests;
  int holds_done;
  int hold_left;

  serial_eeprom_bus_interface i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .operation  (operation),
    .address    (address),
    .write_data (write_data),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .read_data  (read_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) tracker.note_access(operation, address, write_data);
      if (rsp_valid && !rsp_stall) tracker.check_read_data(read_data);
    end
  end

  // The receiver stalls at random, and holds off for a long stretch on request.
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else begin
        rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
    end
  end

  task automatic bus_access(input logic op, input logic [23:0] a, input logic [7:0] wd);
    while ($urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    operation  <= op;
    address    <= a;
    write_data <= wd;
    do @(posedge clk); while (req_stall);
    items_sent++;
  endtask

  task automatic send_bits(input logic [15:0] val, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      bus_access(OPER_WRITE, PORT_DI, {7'($urandom), val[i]});
    end
  endtask

  task automatic read_out(input int n);
    repeat (n) bus_access(OPER_READ, PORT_DO, 8'($urandom));
  endtask

  task automatic run_command(input logic [1:0] opc, input logic [ADDRESS_BITS-1:0] a,
                             input logic [WORD_BITS-1:0] w);
    logic lead;
    int   pick;
    lead = ($urandom_range(9) != 0);
    send_bits({13'b0, lead, opc}, 3);
    send_bits(16'(a), ADDRESS_BITS);
    if (opc == OPC_WRITE || (opc == OPC_EXT && a[ADDRESS_BITS-1 -: 2] == SUB_WRAL)) begin
      send_bits(16'(w), WORD_BITS);
    end
    if (opc == OPC_READ) begin
      pick = $urandom_range(19);
      if (pick == 0) read_out($urandom_range(15));
      else if (pick == 1) read_out(WORD_BITS + 1);
      else read_out(WORD_BITS);
    end else begin
      read_out($urandom_range(2));
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic random_traffic(input int target);
    int                      pick;
    logic [ADDRESS_BITS-1:0] a;
    logic [WORD_BITS-1:0]    w;
    logic [23:0]             spot;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        bus_access(1'($urandom), PORT_CS, 8'($urandom));
      end else if (pick < 20) begin
        case ($urandom_range(4))
          0:       spot = PORT_DO;
          1:       spot = PORT_DI;
          2:       spot = PORT_CS;
          3:       spot = PORT_DI ^ (24'h1 << $urandom_range(23));
          default: spot = 24'($urandom);
        endcase
        bus_access(1'($urandom), spot, 8'($urandom));
      end else begin
        a = $urandom_range(1) ? ADDRESS_BITS'($urandom_range(7)) : ADDRESS_BITS'($urandom);
        case ($urandom_range(3))
          0:       w = '0;
          1:       w = '1;
          default: w = WORD_BITS'($urandom);
        endcase
        run_command(2'($urandom), a, w);
      end
    end
  endtask

  initial begin
    tracker = new;
    tracker.clear();
    items_sent    = 0;
    req_idle_pct  = 26;
    rsp_idle_pct  = 56;
    hold_requests = 0;
    holds_done    = 0;
    hold_left     = 0;
    rst        <= 1'b1;
    req_valid  <= 1'b0;
    operation  <= OPER_READ;
    address    <= '0;
    write_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    bus_access(OPER_READ, 24'h000000, 8'h00);
    bus_access(OPER_WRITE, 24'hFFFFFF, 8'hFF);
    bus_access(OPER_WRITE, PORT_DO, 8'h00);
    bus_access(OPER_READ, PORT_DO, 8'hFF);
    bus_access(OPER_READ, PORT_DI, 8'h00);
    bus_access(OPER_READ, PORT_CS, 8'h00);
    // Erase of the top word, led by a start bit of zero, then the busy read.
    send_bits({13'b0, 1'b0, OPC_ERASE}, 3);
    send_bits(16'(ADDRESS_BITS'('1)), ADDRESS_BITS);
    read_out(2);
    bus_access(OPER_WRITE, PORT_CS, 8'h55);
    bus_access(OPER_WRITE, PORT_DI, 8'hFE);
    bus_access(OPER_READ, PORT_CS, 8'hAA);

    hold_requests++;
    random_traffic(500);
    drain();
    req_idle_pct = 56;
    rsp_idle_pct = 26;
    random_traffic(1000);
    drain();
    req_idle_pct = 0;
    rsp_idle_pct = 0;
    hold_requests++;
    random_traffic(1450);

    req_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
